### src/substring_search_first_match_defines.svh
// Assertion macros used by the substring search top level.
`ifndef SUBSTRING_SEARCH_FIRST_MATCH_DEFINES_SVH
`define SUBSTRING_SEARCH_FIRST_MATCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that the consequent holds in the same cycle as the antecedent.
`define SSFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssfm assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SSFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssfm assertion failed");

`else

`define SSFM_ASSERT_NOW(label, clk, rst, ante, cons)

`define SSFM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/ssfm_pkg.sv
// Shared constants and types of the substring search block.
`default_nettype none

package ssfm_pkg;

   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 16;
   localparam int LEN_W       = 5;
   localparam int REG_BYTES   = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_LEN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_HIGH = 2'd2;

   // Needle as the front end sees it
   typedef struct packed {
      logic [LEN_W-1:0]                  eff_len;
      logic [REG_BYTES-1:0][BYTE_W-1:0]  needle;
   } needle_cfg_type;

   // Classified request passed from front to back
   typedef struct packed {
      logic                is_term;
      logic                found;
      logic [OFFSET_W-1:0] offset;
   } mid_item_type;

   // Result item
   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
   } rsp_item_type;

endpackage

`default_nettype wire

### src/ssfm_fifo.sv
// Small flop-based first-in first-out queue.
`default_nettype none

module ssfm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### src/ssfm_csr.sv
// Configuration registers and effective needle length.
`default_nettype none

module ssfm_csr #(
   parameter int NEEDLE_MAX = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ssfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ssfm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ssfm_pkg::needle_cfg_type              cfg
);

   import ssfm_pkg::*;

   localparam int CAP = (NEEDLE_MAX < REG_BYTES) ? NEEDLE_MAX : REG_BYTES;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

   logic [LEN_W-1:0]      len_ff, len_in;
   logic [CSR_DATA_W-1:0] low_ff, low_in;
   logic [CSR_DATA_W-1:0] high_ff, high_in;
   logic [LEN_W-1:0]      eff_len_ff, eff_len_in;
   logic [REG_BYTES-1:0][BYTE_W-1:0] bytes_in;
   logic [LEN_W-1:0]      len_cap;

   // Decode writes
   always_comb begin
      len_in  = len_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NEEDLE_LEN:  len_in  = csr_wdata[LEN_W-1:0];
            CSR_NEEDLE_LOW:  low_in  = csr_wdata;
            CSR_NEEDLE_HIGH: high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Cap the length and cut the needle at its first zero byte
   always_comb begin
      bytes_in   = {high_in, low_in};
      len_cap    = (len_in > CAP_LEN) ? CAP_LEN : len_in;
      eff_len_in = len_cap;
      for (int i = REG_BYTES - 1; i >= 0; i--) begin
         if ((LEN_W'(i) < len_cap) && (bytes_in[i] == TERM_BYTE)) begin
            eff_len_in = LEN_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
         eff_len_ff <= '0;
      end else begin
         len_ff     <= len_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         eff_len_ff <= eff_len_in;
      end
   end

   assign cfg.eff_len = eff_len_ff;
   assign cfg.needle  = {high_ff, low_ff};

endmodule

`default_nettype wire

### src/ssfm_front.sv
// Front end: byte window, position and per-request match classification.
`default_nettype none

module ssfm_front #(
   parameter int NEEDLE_MAX    = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [ssfm_pkg::BYTE_W-1:0] hay_byte,
   input  ssfm_pkg::needle_cfg_type         cfg,
   output logic                            mid_push,
   output ssfm_pkg::mid_item_type          mid_item
);

   import ssfm_pkg::*;

   localparam int CAP       = (NEEDLE_MAX < REG_BYTES) ? NEEDLE_MAX : REG_BYTES;
   localparam int WIN_DEPTH = (CAP > 1) ? CAP - 1 : 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   logic [BYTE_W-1:0]        win_ff [WIN_DEPTH];
   logic [BYTE_W-1:0]        win_in [WIN_DEPTH];
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [BYTE_W-1:0]        cur [CAP];
   logic [CAP-1:0]           hit_len;
   logic [CAP-1:0]           len_sel;
   logic                     is_term, empty_needle, hit, cand;
   logic [POSITION_BITS-1:0] back_len, off_pos;
   logic [POSITION_BITS+OFFSET_W-1:0] off_ext;

   assign is_term      = (hay_byte == TERM_BYTE);
   assign empty_needle = (cfg.eff_len == '0);

   // Window with the incoming byte at the newest end
   always_comb begin
      cur[0] = hay_byte;
      for (int k = 1; k < CAP; k++) begin
         cur[k] = win_ff[k-1];
      end
   end

   // Compare every candidate needle length in parallel
   always_comb begin
      logic ok;
      for (int l = 1; l <= CAP; l++) begin
         ok = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (cur[l-1-i] != cfg.needle[i]) begin
               ok = 1'b0;
            end
         end
         hit_len[l-1] = ok;
         len_sel[l-1] = (cfg.eff_len == LEN_W'(l));
      end
   end

   assign hit  = |(hit_len & len_sel);
   assign cand = empty_needle ? (pos_ff == '0) : hit;

   // Offset of the first matched byte, floored at zero
   always_comb begin
      back_len = POSITION_BITS'(cfg.eff_len) - 1'b1;
      off_pos  = '0;
      if (!empty_needle && (pos_ff >= back_len)) begin
         off_pos = pos_ff - back_len;
      end
      off_ext = {{OFFSET_W{1'b0}}, off_pos};
   end

   // Classify the request for the back end
   always_comb begin
      mid_push         = accept && (is_term || cand);
      mid_item.is_term = is_term;
      mid_item.found   = is_term ? empty_needle : 1'b1;
      mid_item.offset  = is_term ? '0 : off_ext[OFFSET_W-1:0];
   end

   // Shift the window and advance the position; clear on a terminator
   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         win_in[k] = win_ff[k];
      end
      pos_in = pos_ff;
      if (accept) begin
         if (is_term) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
               win_in[k] = '0;
            end
            pos_in = '0;
         end else begin
            win_in[0] = hay_byte;
            for (int k = 1; k < WIN_DEPTH; k++) begin
               win_in[k] = win_ff[k-1];
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ff[k] <= '0;
         end
         pos_ff <= '0;
      end else begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ff[k] <= win_in[k];
         end
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

### src/ssfm_back.sv
// Back end: first-answer bookkeeping and result generation.
`default_nettype none

module ssfm_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 mid_empty,
   input  ssfm_pkg::mid_item_type    mid_item,
   output logic                      mid_pop,
   input  wire logic                 out_full,
   output logic                      out_push,
   output ssfm_pkg::rsp_item_type    out_item
);

   import ssfm_pkg::*;

   logic answered_ff, answered_in;

   // Emit only the first answer of a haystack; drop the rest
   assign out_push        = !mid_empty && !answered_ff && !out_full;
   assign mid_pop         = !mid_empty && (answered_ff || !out_full);
   assign out_item.found  = mid_item.found;
   assign out_item.offset = mid_item.offset;

   // Hold the answered flag until the terminator
   always_comb begin
      answered_in = answered_ff;
      if (mid_pop) begin
         answered_in = !mid_item.is_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         answered_ff <= 1'b0;
      end else begin
         answered_ff <= answered_in;
      end
   end

endmodule

`default_nettype wire

### src/substring_search_first_match.sv
// Top level of the streaming first-match substring search.
`default_nettype none

// Streams haystack bytes, one per request, and reports the offset of the
// first occurrence of the configured needle; a zero byte ends the haystack,
// gives not-found if nothing matched, and clears the search. The block takes
// one byte per clock cycle while req_full is low: the front end compares the
// whole byte window with the needle combinationally, and a two-entry queue
// separates it from the back end, which keeps the first-answer flag and feeds
// a two-entry result queue. A result passes through both queues before it
// reaches the rsp ports. Needle registers may be written between requests and
// apply to the next byte.
`include "substring_search_first_match_defines.svh"

module substring_search_first_match #(
   parameter int NEEDLE_MAX    = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [ssfm_pkg::BYTE_W-1:0]      req_hay_byte,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_found,
   output logic [ssfm_pkg::OFFSET_W-1:0]         rsp_match_offset,
   input  wire logic                             csr_wr_en,
   input  wire logic [ssfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ssfm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import ssfm_pkg::*;

   localparam int MID_W = $bits(mid_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   needle_cfg_type cfg;
   logic           accept;
   logic           mid_push, mid_pop, mid_full, mid_empty;
   mid_item_type   mid_in_item, mid_out_item;
   logic           out_push, out_full;
   rsp_item_type   out_in_item, out_head;

   assign accept   = req_push && !mid_full;
   assign req_full = mid_full;

   // Configuration
   ssfm_csr #(
      .NEEDLE_MAX (NEEDLE_MAX)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Window compare and classification
   ssfm_front #(
      .NEEDLE_MAX    (NEEDLE_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .hay_byte (req_hay_byte),
      .cfg      (cfg),
      .mid_push (mid_push),
      .mid_item (mid_in_item)
   );

   // Queue between front and back
   ssfm_fifo #(
      .WIDTH (MID_W),
      .DEPTH (2)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_item),
      .empty     (mid_empty)
   );

   // First-answer filter
   ssfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_out_item),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_in_item)
   );

   // Result queue
   ssfm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_head),
      .empty     (rsp_empty)
   );

   assign rsp_found        = out_head.found;
   assign rsp_match_offset = out_head.offset;

   // A terminator request always reaches the back end
   `SSFM_ASSERT_NOW(a_term_forwarded, clock, reset,
      accept && (req_hay_byte == TERM_BYTE), mid_push)
   // A result is produced only while draining the front queue
   `SSFM_ASSERT_NOW(a_push_with_pop, clock, reset, out_push, mid_pop)
   // A not-found result carries a zero offset
   `SSFM_ASSERT_NOW(a_notfound_zero, clock, reset,
      out_push && !out_in_item.found, out_in_item.offset == '0)
   // A classified request is waiting in the queue on the next cycle
   `SSFM_ASSERT_NEXT(a_mid_filled, clock, reset, mid_push, !mid_empty)

endmodule

`default_nettype wire
